// File: rtl/smx_pkg.sv
// ============================================================================
// smx_pkg - shared types and constants for the stack machine executor
// Transaction structs, opcodes, command codes, run modes and sequencer states.
// ============================================================================
package smx_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam int WIDX_BITS     = MEM_ADDR_BITS - 2;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] address;
        logic [31:0] data;
    } t_in;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
        logic [2:0]  host_call;
        logic [15:0] program_counter;
        logic [15:0] stack_pointer;
        logic [31:0] step_count;
    } t_out;

    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_EXEC   = 3'd2;
    localparam logic [2:0] CMD_RESUME = 3'd3;
    localparam logic [2:0] CMD_START  = 3'd4;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_RUN   = 3'd1,
        MODE_CALL  = 3'd2,
        MODE_HALT  = 3'd3,
        MODE_BADOP = 3'd4,
        MODE_DIVZ  = 3'd5
    } t_mode;

    localparam logic [5:0] OP_LEA  = 6'd0;
    localparam logic [5:0] OP_IMM  = 6'd1;
    localparam logic [5:0] OP_JMP  = 6'd2;
    localparam logic [5:0] OP_JSR  = 6'd3;
    localparam logic [5:0] OP_BZ   = 6'd4;
    localparam logic [5:0] OP_BNZ  = 6'd5;
    localparam logic [5:0] OP_ENT  = 6'd6;
    localparam logic [5:0] OP_ADJ  = 6'd7;
    localparam logic [5:0] OP_LEV  = 6'd8;
    localparam logic [5:0] OP_LI   = 6'd9;
    localparam logic [5:0] OP_LC   = 6'd10;
    localparam logic [5:0] OP_SI   = 6'd11;
    localparam logic [5:0] OP_SC   = 6'd12;
    localparam logic [5:0] OP_PSH  = 6'd13;
    localparam logic [5:0] OP_OR   = 6'd14;
    localparam logic [5:0] OP_XOR  = 6'd15;
    localparam logic [5:0] OP_AND  = 6'd16;
    localparam logic [5:0] OP_EQ   = 6'd17;
    localparam logic [5:0] OP_NE   = 6'd18;
    localparam logic [5:0] OP_LT   = 6'd19;
    localparam logic [5:0] OP_GT   = 6'd20;
    localparam logic [5:0] OP_LE   = 6'd21;
    localparam logic [5:0] OP_GE   = 6'd22;
    localparam logic [5:0] OP_SHL  = 6'd23;
    localparam logic [5:0] OP_SHR  = 6'd24;
    localparam logic [5:0] OP_ADD  = 6'd25;
    localparam logic [5:0] OP_SUB  = 6'd26;
    localparam logic [5:0] OP_MUL  = 6'd27;
    localparam logic [5:0] OP_DIV  = 6'd28;
    localparam logic [5:0] OP_MOD  = 6'd29;
    localparam logic [5:0] OP_OPEN = 6'd30;
    localparam logic [5:0] OP_MCMP = 6'd36;
    localparam logic [5:0] OP_EXIT = 6'd37;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_OP_WAIT,
        S_IMM_WAIT,
        S_EXEC,
        S_POP_WAIT,
        S_SC_WAIT,
        S_DIV,
        S_LEV_WAIT1,
        S_LEV_WAIT2,
        S_LD_WAIT,
        S_DONE
    } t_state;

    // byte address -> word index, wrapping modulo the memory depth
    function automatic logic [WIDX_BITS-1:0] word_index(input logic [15:0] addr);
        logic [WIDX_BITS+13:0] wide;
        wide = {{WIDX_BITS{1'b0}}, addr[15:2]};
        return wide[WIDX_BITS-1:0];
    endfunction

endpackage

// File: rtl/smx_ram.sv
// ============================================================================
// smx_ram - single-port word RAM
// One read or one write per cycle, registered read data.
// ============================================================================
module smx_ram #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:(1<<ADDR_W)-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/smx_alu.sv
// ============================================================================
// smx_alu - combinational ALU for the binary stack operations except DIV/MOD
// Left operand is the popped word, right operand the accumulator.
// ============================================================================
module smx_alu (
    input  logic [5:0]  i_op,
    input  logic [31:0] i_b,
    input  logic [31:0] i_a,
    output logic [31:0] o_result
);
    import smx_pkg::*;

    logic [4:0] sh;
    logic       b_lt_a;
    logic       a_lt_b;

    assign sh     = i_a[4:0];
    assign b_lt_a = $signed(i_b) < $signed(i_a);
    assign a_lt_b = $signed(i_a) < $signed(i_b);

    always_comb begin
        case (i_op)
            OP_OR:   o_result = i_b | i_a;
            OP_XOR:  o_result = i_b ^ i_a;
            OP_AND:  o_result = i_b & i_a;
            OP_EQ:   o_result = {31'd0, i_b == i_a};
            OP_NE:   o_result = {31'd0, i_b != i_a};
            OP_LT:   o_result = {31'd0, b_lt_a};
            OP_GT:   o_result = {31'd0, a_lt_b};
            OP_LE:   o_result = {31'd0, !a_lt_b};
            OP_GE:   o_result = {31'd0, !b_lt_a};
            OP_SHL:  o_result = i_b << sh;
            OP_SHR:  o_result = $unsigned($signed(i_b) >>> sh);
            OP_ADD:  o_result = i_b + i_a;
            OP_SUB:  o_result = i_b - i_a;
            OP_MUL:  o_result = i_b * i_a;
            default: o_result = 32'd0;
        endcase
    end

endmodule

// File: rtl/smx_div.sv
// ============================================================================
// smx_div - radix-2 restoring divider, unsigned 32 by 32
// One quotient bit per cycle; done pulses once the last quotient bit is in.
// ============================================================================
module smx_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quot;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {r_rem, r_quot[31]};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_quot <= i_dividend;
                r_rem  <= 32'd0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (!diff[32]) begin
                    r_rem  <= diff[31:0];
                    r_quot <= {r_quot[30:0], 1'b1};
                end else begin
                    r_rem  <= shifted[31:0];
                    r_quot <= {r_quot[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// File: rtl/stack_machine_executor.sv
// ============================================================================
// stack_machine_executor - accumulator/stack virtual machine with word memory
// Host commands: word write, word read, execute one instruction, resume after
// a host call, start. Every command returns one status transaction.
// ============================================================================
// A transaction is stepped by the sequencer around one single-port memory,
// which serves one read or write per cycle. An instruction does an opcode
// fetch, an operand fetch for opcodes 0..7 and at most one stack or data
// access (LEV and SI two, SC three); DIV and MOD also wait on the
// one-bit-per-cycle divider. The input is stalled while a command is in
// work; a finished result waits in the output register, so the next command
// may be taken while the previous result is still stalled. Memory is not
// cleared: host code must write every word before it is read.
module stack_machine_executor (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  smx_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output smx_pkg::t_out   o_out_data,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [15:0]     i_cfg_data
);
    import smx_pkg::*;

    // sequencer and architectural state
    t_state      r_state, n_state;
    t_mode       r_mode;
    logic [15:0] r_pc, r_sp, r_bp;
    logic [31:0] r_acc, r_steps;
    logic [2:0]  r_call;
    logic [15:0] r_cfg_start, r_cfg_stack;

    // latched transaction and instruction words
    logic [2:0]  r_cmd;
    logic [15:0] r_addr;
    logic [31:0] r_data;
    logic [5:0]  r_op;
    logic        r_op_bad;
    logic [31:0] r_imm;
    logic [31:0] r_b;
    logic [31:0] r_rdv;

    logic        r_out_valid;
    t_out        r_out;

    // memory request
    logic        m_en, m_we;
    logic [15:0] m_addr;
    logic [31:0] m_wdata, m_rdata;

    logic        in_acc, out_free;
    logic [15:0] pcv, sp_dn, exec_pc;
    logic [31:0] alu_res;
    logic        div_start, div_busy, div_done;
    logic [31:0] div_q, div_r, b_abs, a_abs;
    logic [31:0] lc_word, sc_merged;
    logic [4:0]  lc_sh, sc_sh;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign pcv      = (r_op <= OP_ADJ) ? r_pc + 16'd8 : r_pc + 16'd4;
    assign sp_dn    = r_sp - 16'd4;
    // jumps, calls and taken branches go to the operand, all else falls through
    assign exec_pc  = (r_op == OP_JMP || r_op == OP_JSR
                       || (r_op == OP_BZ && r_acc == 32'd0)
                       || (r_op == OP_BNZ && r_acc != 32'd0)) ? r_imm[15:0] : pcv;
    assign b_abs    = m_rdata[31] ? 32'd0 - m_rdata : m_rdata;
    assign a_abs    = r_acc[31] ? 32'd0 - r_acc : r_acc;
    assign lc_sh    = {r_acc[1:0], 3'b000};
    assign lc_word  = m_rdata >> lc_sh;
    assign sc_sh    = {r_b[1:0], 3'b000};
    assign sc_merged = (m_rdata & ~(32'h0000_00FF << sc_sh))
                     | ({24'd0, r_acc[7:0]} << sc_sh);

    smx_ram #(.ADDR_W(WIDX_BITS), .DATA_W(32)) u_ram (
        .i_clk   (i_clk),
        .i_en    (m_en),
        .i_we    (m_we),
        .i_addr  (word_index(m_addr)),
        .i_wdata (m_wdata),
        .o_rdata (m_rdata)
    );

    smx_alu u_alu (
        .i_op     (r_op),
        .i_b      (m_rdata),
        .i_a      (r_acc),
        .o_result (alu_res)
    );

    smx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (b_abs),
        .i_divisor  (a_abs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (in_acc) n_state = S_DECODE;
            S_DECODE: begin
                if (r_cmd == CMD_READ) begin
                    n_state = S_RD_WAIT;
                end else if (r_cmd == CMD_EXEC && r_mode == MODE_RUN) begin
                    n_state = S_OP_WAIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD_WAIT:   n_state = S_DONE;
            S_OP_WAIT:   n_state = (m_rdata <= 32'(OP_ADJ)) ? S_IMM_WAIT : S_EXEC;
            S_IMM_WAIT:  n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_DONE;
                if (!r_op_bad &&
                    !((r_op == OP_DIV || r_op == OP_MOD) && r_acc == 32'd0)) begin
                    case (r_op) inside
                        [OP_OR:OP_MOD], OP_SI, OP_SC: n_state = S_POP_WAIT;
                        OP_LEV:                        n_state = S_LEV_WAIT1;
                        OP_LI, OP_LC, OP_EXIT:         n_state = S_LD_WAIT;
                        default:                       n_state = S_DONE;
                    endcase
                end
            end
            S_POP_WAIT: begin
                if (r_op == OP_SC) begin
                    n_state = S_SC_WAIT;
                end else if (r_op == OP_DIV || r_op == OP_MOD) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SC_WAIT:   n_state = S_DONE;
            S_DIV:       if (div_done) n_state = S_DONE;
            S_LEV_WAIT1: n_state = S_LEV_WAIT2;
            S_LEV_WAIT2: n_state = S_DONE;
            S_LD_WAIT:   n_state = S_DONE;
            S_DONE:      if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // ---------------- sequencer outputs: memory port and divider ----------------
    always_comb begin
        m_en      = 1'b0;
        m_we      = 1'b0;
        m_addr    = 16'd0;
        m_wdata   = 32'd0;
        div_start = 1'b0;
        unique case (r_state)
            S_DECODE: begin
                if (r_cmd == CMD_WRITE) begin
                    m_en = 1'b1; m_we = 1'b1; m_addr = r_addr; m_wdata = r_data;
                end else if (r_cmd == CMD_READ) begin
                    m_en = 1'b1; m_addr = r_addr;
                end else if (r_cmd == CMD_EXEC && r_mode == MODE_RUN) begin
                    m_en = 1'b1; m_addr = r_pc;
                end
            end
            S_OP_WAIT: begin
                m_en   = 1'b1;
                m_addr = r_pc + 16'd4;
            end
            S_EXEC: begin
                if (!r_op_bad &&
                    !((r_op == OP_DIV || r_op == OP_MOD) && r_acc == 32'd0)) begin
                    case (r_op) inside
                        [OP_OR:OP_MOD], OP_SI, OP_SC, OP_EXIT: begin
                            m_en = 1'b1; m_addr = r_sp;
                        end
                        OP_LEV: begin
                            m_en = 1'b1; m_addr = r_bp;
                        end
                        OP_LI, OP_LC: begin
                            m_en = 1'b1; m_addr = r_acc[15:0];
                        end
                        OP_JSR: begin
                            m_en = 1'b1; m_we = 1'b1; m_addr = sp_dn;
                            m_wdata = {16'd0, pcv};
                        end
                        OP_ENT: begin
                            m_en = 1'b1; m_we = 1'b1; m_addr = sp_dn;
                            m_wdata = {16'd0, r_bp};
                        end
                        OP_PSH: begin
                            m_en = 1'b1; m_we = 1'b1; m_addr = sp_dn; m_wdata = r_acc;
                        end
                        default: ;
                    endcase
                end
            end
            S_POP_WAIT: begin
                if (r_op == OP_SI) begin
                    m_en = 1'b1; m_we = 1'b1; m_addr = m_rdata[15:0]; m_wdata = r_acc;
                end else if (r_op == OP_SC) begin
                    m_en = 1'b1; m_addr = m_rdata[15:0];
                end else if (r_op == OP_DIV || r_op == OP_MOD) begin
                    div_start = 1'b1;
                end
            end
            S_SC_WAIT: begin
                m_en = 1'b1; m_we = 1'b1; m_addr = r_b[15:0]; m_wdata = sc_merged;
            end
            S_LEV_WAIT1: begin
                m_en = 1'b1; m_addr = r_sp + 16'd4;
            end
            default: ;
        endcase
    end

    // ---------------- state and datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_IDLE;
            r_pc        <= 16'd0;
            r_sp        <= 16'd0;
            r_bp        <= 16'd0;
            r_acc       <= 32'd0;
            r_steps     <= 32'd0;
            r_call      <= 3'd0;
            r_cfg_start <= 16'd0;
            r_cfg_stack <= 16'd65532;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_index) r_cfg_stack <= i_cfg_data;
                else             r_cfg_start <= i_cfg_data;
            end

            // a new result may load in the same cycle the old one leaves
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd  <= i_in_data.command;
                        r_addr <= i_in_data.address;
                        r_data <= i_in_data.data;
                    end
                end
                S_DECODE: begin
                    if (r_cmd == CMD_RESUME && r_mode == MODE_CALL) begin
                        r_acc  <= r_data;
                        r_call <= 3'd0;
                        r_mode <= MODE_RUN;
                    end else if (r_cmd == CMD_START) begin
                        r_pc    <= r_cfg_start;
                        r_sp    <= r_cfg_stack;
                        r_bp    <= 16'd0;
                        r_acc   <= 32'd0;
                        r_steps <= 32'd0;
                        r_call  <= 3'd0;
                        r_mode  <= MODE_RUN;
                    end
                end
                S_RD_WAIT: r_rdv <= m_rdata;
                S_OP_WAIT: begin
                    r_op     <= m_rdata[5:0];
                    r_op_bad <= (m_rdata > 32'(OP_EXIT));
                    r_steps  <= r_steps + 32'd1;
                end
                S_IMM_WAIT: r_imm <= m_rdata;
                S_EXEC: begin
                    if ((r_op == OP_DIV || r_op == OP_MOD) && !r_op_bad
                        && r_acc == 32'd0) begin
                        r_mode <= MODE_DIVZ;
                    end else if (r_op_bad) begin
                        r_mode <= MODE_BADOP;
                    end else begin
                        r_pc <= exec_pc;
                        case (r_op) inside
                            [OP_OR:OP_MOD], OP_SI, OP_SC: r_sp <= r_sp + 16'd4;
                            OP_LEA: r_acc <= {16'd0, r_bp} + {r_imm[29:0], 2'b00};
                            OP_IMM: r_acc <= r_imm;
                            OP_JSR: r_sp <= sp_dn;
                            OP_ENT: begin
                                r_bp <= sp_dn;
                                r_sp <= sp_dn - {r_imm[13:0], 2'b00};
                            end
                            OP_ADJ: r_sp <= r_sp + {r_imm[13:0], 2'b00};
                            OP_LEV: r_sp <= r_bp;
                            OP_PSH: r_sp <= sp_dn;
                            [OP_OPEN:OP_MCMP]: begin
                                r_call <= 3'(r_op - OP_OPEN);
                                r_mode <= MODE_CALL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_POP_WAIT: begin
                    r_b <= m_rdata;
                    if (r_op != OP_SI && r_op != OP_SC && r_op != OP_DIV
                        && r_op != OP_MOD) begin
                        r_acc <= alu_res;
                    end
                end
                S_SC_WAIT: r_acc <= {{24{r_acc[7]}}, r_acc[7:0]};
                S_DIV: begin
                    if (div_done) begin
                        if (r_op == OP_DIV) begin
                            r_acc <= (r_b[31] ^ r_acc[31]) ? 32'd0 - div_q : div_q;
                        end else begin
                            r_acc <= r_b[31] ? 32'd0 - div_r : div_r;
                        end
                    end
                end
                S_LEV_WAIT1: begin
                    r_bp <= m_rdata[15:0];
                    r_sp <= r_sp + 16'd4;
                end
                S_LEV_WAIT2: begin
                    r_pc <= m_rdata[15:0];
                    r_sp <= r_sp + 16'd4;
                end
                S_LD_WAIT: begin
                    if (r_op == OP_LC) begin
                        r_acc <= {{24{lc_word[7]}}, lc_word[7:0]};
                    end else begin
                        r_acc <= m_rdata;
                        if (r_op == OP_EXIT) r_mode <= MODE_HALT;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register, loaded as the transaction completes
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.value           <= (r_cmd == CMD_READ) ? r_rdv : r_acc;
            r_out.status          <= r_mode;
            r_out.host_call       <= r_call;
            r_out.program_counter <= r_pc;
            r_out.stack_pointer   <= r_sp;
            r_out.step_count      <= r_steps;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    a_call_only_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_CALL) |-> (r_call == 3'd0))
        else $error("host call code set without a pending call");

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !m_en)
        else $error("memory accessed while idle");

    a_steps_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_state != S_OP_WAIT
         && !(r_state == S_DECODE && r_cmd == CMD_START)) |=> $stable(r_steps))
        else $error("step count changed outside an instruction fetch");

endmodule

// File: tb/tb.sv
// ============================================================================
// tb - self-checking testbench for the stack machine executor
// Walks a short directed table, then runs random programs: config, program
// load, start and single-step execution with host call traffic and noise.
// Every result is checked against a typed status or a cycle-free predictor.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import smx_pkg::*;

    localparam int          N_ITEMS    = 1650;
    localparam int          SETTLE     = 60;   // covers the slowest command (DIV)
    localparam int          LONG_HOLD  = 300;
    localparam logic        CFG_START  = 1'b0;
    localparam logic        CFG_STACK  = 1'b1;
    localparam logic [5:0]  OP_PRTF    = OP_OPEN + 6'd3;
    localparam logic [31:0] BAD_OPCODE = 32'd50;
    localparam logic [2:0]  CMD_BAD_LO = 3'd5;
    localparam logic [2:0]  CMD_BAD_HI = 3'd7;

    // fill kinds for words the next command would read before they exist
    localparam int FILL_DATA = 0;
    localparam int FILL_OPC  = 1;
    localparam int FILL_ARG  = 2;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    t_in   in_data = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    t_out  out_data;
    logic  cfg_we = 1'b0;
    logic  cfg_index = 1'b0;
    logic  [15:0] cfg_data = '0;

    always #5 i_clk = ~i_clk;

    stack_machine_executor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Machine predictor: architectural state plus a sparse word memory
    // ------------------------------------------------------------------
    logic [31:0] vm_mem [int];
    logic [15:0] vm_pc, vm_sp, vm_bp;
    logic [31:0] vm_acc, vm_steps;
    t_mode       vm_mode;
    logic [2:0]  vm_call;
    logic [15:0] cfg_start_addr, cfg_stack_top;

    t_out status_q[$];      // expected status transactions, oldest first
    int   n_sent, n_checked, n_errors;
    int   n_exec, n_calls, n_halts, n_faults;
    bit   hold_req;

    function automatic int widx(input logic [15:0] a);
        return int'(a[15:2]) % (1 << WIDX_BITS);
    endfunction

    function automatic bit written(input logic [15:0] a);
        return vm_mem.exists(widx(a));
    endfunction

    function automatic logic [31:0] mem_get(input logic [15:0] a);
        return written(a) ? vm_mem[widx(a)] : 32'h0;
    endfunction

    function automatic void mem_put(input logic [15:0] a, input logic [31:0] v);
        vm_mem[widx(a)] = v;
    endfunction

    function automatic void vm_push(input logic [31:0] v);
        vm_sp = vm_sp - 16'd4;
        mem_put(vm_sp, v);
    endfunction

    function automatic logic [31:0] vm_pop();
        logic [31:0] v;
        v = mem_get(vm_sp);
        vm_sp = vm_sp + 16'd4;
        return v;
    endfunction

    function automatic logic [31:0] sext_byte(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic void vm_reset();
        vm_mem.delete();
        vm_pc = '0; vm_sp = '0; vm_bp = '0;
        vm_acc = '0; vm_steps = '0;
        vm_mode = MODE_IDLE; vm_call = '0;
        cfg_start_addr = '0; cfg_stack_top = 16'd65532;
    endfunction

    // one instruction at pc
    function automatic void vm_execute();
        logic [15:0] nxt;
        logic [31:0] op, imm, b, ua, ub, q, w;
        logic [4:0]  sh;
        logic [4:0]  bs;
        nxt = vm_pc + 16'd4;
        op  = mem_get(vm_pc);
        imm = '0;
        vm_steps++;
        n_exec++;
        if (op <= 32'(OP_ADJ)) begin
            imm = mem_get(nxt);
            nxt = nxt + 16'd4;
        end
        // divide by zero and bad opcode both freeze pc, sp and acc
        if ((op == 32'(OP_DIV) || op == 32'(OP_MOD)) && vm_acc == 0) begin
            vm_mode = MODE_DIVZ; n_faults++;
            return;
        end
        if (op > 32'(OP_EXIT)) begin
            vm_mode = MODE_BADOP; n_faults++;
            return;
        end
        vm_pc = nxt;
        if (op >= 32'(OP_OR) && op <= 32'(OP_MOD)) begin
            b  = vm_pop();
            sh = vm_acc[4:0];
            case (op[5:0])
                OP_OR:  vm_acc = b | vm_acc;
                OP_XOR: vm_acc = b ^ vm_acc;
                OP_AND: vm_acc = b & vm_acc;
                OP_EQ:  vm_acc = 32'(b == vm_acc);
                OP_NE:  vm_acc = 32'(b != vm_acc);
                OP_LT:  vm_acc = 32'($signed(b) < $signed(vm_acc));
                OP_GT:  vm_acc = 32'($signed(vm_acc) < $signed(b));
                OP_LE:  vm_acc = 32'(!($signed(vm_acc) < $signed(b)));
                OP_GE:  vm_acc = 32'(!($signed(b) < $signed(vm_acc)));
                OP_SHL: vm_acc = b << sh;
                OP_SHR: vm_acc = $unsigned($signed(b) >>> sh);
                OP_ADD: vm_acc = b + vm_acc;
                OP_SUB: vm_acc = b - vm_acc;
                OP_MUL: vm_acc = b * vm_acc;
                default: begin
                    // magnitudes, so the most negative value wraps cleanly
                    ua = b[31] ? -b : b;
                    ub = vm_acc[31] ? -vm_acc : vm_acc;
                    if (op[5:0] == OP_DIV) begin
                        q = ua / ub;
                        vm_acc = (b[31] ^ vm_acc[31]) ? -q : q;
                    end else begin
                        q = ua % ub;
                        vm_acc = b[31] ? -q : q;
                    end
                end
            endcase
            return;
        end
        case (op[5:0])
            OP_LEA: vm_acc = {16'h0, vm_bp} + imm * 4;
            OP_IMM: vm_acc = imm;
            OP_JMP: vm_pc = imm[15:0];
            OP_JSR: begin
                vm_push({16'h0, nxt});
                vm_pc = imm[15:0];
            end
            OP_BZ:  if (vm_acc == 0) vm_pc = imm[15:0];
            OP_BNZ: if (vm_acc != 0) vm_pc = imm[15:0];
            OP_ENT: begin
                vm_push({16'h0, vm_bp});
                vm_bp = vm_sp;
                vm_sp = vm_sp - 16'(imm * 4);
            end
            OP_ADJ: vm_sp = vm_sp + 16'(imm * 4);
            OP_LEV: begin
                vm_sp = vm_bp;
                vm_bp = 16'(vm_pop());
                vm_pc = 16'(vm_pop());
            end
            OP_LI:  vm_acc = mem_get(vm_acc[15:0]);
            OP_LC: begin
                w = mem_get(vm_acc[15:0]) >> (8 * vm_acc[1:0]);
                vm_acc = sext_byte(w[7:0]);
            end
            OP_SI: begin
                b = vm_pop();
                mem_put(b[15:0], vm_acc);
            end
            OP_SC: begin
                b  = vm_pop();
                bs = {b[1:0], 3'b000};
                w  = (mem_get(b[15:0]) & ~(32'hFF << bs)) | ({24'h0, vm_acc[7:0]} << bs);
                mem_put(b[15:0], w);
                vm_acc = sext_byte(vm_acc[7:0]);
            end
            OP_PSH: vm_push(vm_acc);
            OP_EXIT: begin
                vm_acc = mem_get(vm_sp);
                vm_mode = MODE_HALT; n_halts++;
            end
            default: begin
                vm_call = 3'(op[5:0] - OP_OPEN);
                vm_mode = MODE_CALL; n_calls++;
            end
        endcase
    endfunction

    function automatic t_out vm_step(input t_in it);
        t_out r;
        case (it.command)
            CMD_WRITE: mem_put(it.address, it.data);
            CMD_EXEC:  if (vm_mode == MODE_RUN) vm_execute();
            CMD_RESUME: if (vm_mode == MODE_CALL) begin
                vm_acc = it.data; vm_call = '0; vm_mode = MODE_RUN;
            end
            CMD_START: begin
                vm_pc = cfg_start_addr; vm_sp = cfg_stack_top; vm_bp = '0;
                vm_acc = '0; vm_steps = '0; vm_call = '0; vm_mode = MODE_RUN;
            end
            default: ;
        endcase
        r.value           = (it.command == CMD_READ) ? mem_get(it.address) : vm_acc;
        r.status          = vm_mode;
        r.host_call       = vm_call;
        r.program_counter = vm_pc;
        r.stack_pointer   = vm_sp;
        r.step_count      = vm_steps;
        return r;
    endfunction

    // First word the command would read that was never written, or -1.
    function automatic int unwritten_read(input t_in it, output int kind);
        logic [31:0] op, b;
        kind = FILL_DATA;
        if (it.command == CMD_READ)
            return written(it.address) ? -1 : int'(it.address);
        if (it.command != CMD_EXEC || vm_mode != MODE_RUN)
            return -1;
        if (!written(vm_pc)) begin
            kind = FILL_OPC;
            return int'(vm_pc);
        end
        op = mem_get(vm_pc);
        if (op <= 32'(OP_ADJ) && !written(vm_pc + 16'd4)) begin
            kind = FILL_ARG;
            return int'(16'(vm_pc + 16'd4));
        end
        if (op > 32'(OP_EXIT)) return -1;
        if ((op == 32'(OP_DIV) || op == 32'(OP_MOD)) && vm_acc == 0) return -1;
        if ((op >= 32'(OP_OR) && op <= 32'(OP_MOD)) || op == 32'(OP_SI)
                || op == 32'(OP_EXIT))
            return written(vm_sp) ? -1 : int'(vm_sp);
        if (op == 32'(OP_SC)) begin
            if (!written(vm_sp)) return int'(vm_sp);
            b = mem_get(vm_sp);
            return written(b[15:0]) ? -1 : int'(b[15:0]);
        end
        if (op == 32'(OP_LEV)) begin
            if (!written(vm_bp)) return int'(vm_bp);
            return written(vm_bp + 16'd4) ? -1 : int'(16'(vm_bp + 16'd4));
        end
        if (op == 32'(OP_LI) || op == 32'(OP_LC))
            return written(vm_acc[15:0]) ? -1 : int'(vm_acc[15:0]);
        return -1;
    endfunction

    function automatic logic [31:0] rand_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)  return 32'(OP_EXIT) + 1 + ($urandom & 32'h7FFF_FFFF);
        if (r < 8)  return 32'(OP_EXIT);
        if (r < 16) return 32'($urandom_range(OP_OPEN, OP_MCMP));
        return 32'($urandom_range(OP_LEA, OP_MOD));
    endfunction

    function automatic logic [31:0] rand_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 32'($urandom_range(0, 16));
        if (r < 75) return {16'h0, cfg_start_addr + 16'($urandom_range(0, 63) * 4)};
        return $urandom;
    endfunction

    function automatic t_out mk_status(input logic [31:0] v, input t_mode m,
                                       input logic [15:0] pc, input logic [15:0] sp,
                                       input logic [31:0] steps);
        t_out r;
        r.value = v; r.status = m; r.host_call = '0;
        r.program_counter = pc; r.stack_pointer = sp; r.step_count = steps;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Called just after a rising edge; returns just after
    // the edge at which the transaction was taken.
    // ------------------------------------------------------------------
    task automatic send(input t_in it, input bit typed, input t_out typed_exp);
        int   gap, r;
        t_out pred;
        r = $urandom_range(0, 99);
        gap = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        pred = vm_step(it);
        status_q.push_back(typed ? typed_exp : pred);
        n_sent++;
        // one long receiver hold-off while we keep pushing commands
        if (n_sent == 600) hold_req = 1'b1;
    endtask

    // Writes whatever the command would read uninitialized, then sends it.
    task automatic issue(input t_in it);
        int   a, kind;
        t_in  f;
        a = unwritten_read(it, kind);
        while (a >= 0) begin
            f.command = CMD_WRITE;
            f.address = a[15:0];
            f.data    = (kind == FILL_OPC) ? rand_opcode() :
                        (kind == FILL_ARG) ? rand_operand() : $urandom;
            send(f, 1'b0, '0);
            a = unwritten_read(it, kind);
        end
        send(it, 1'b0, '0);
    endtask

    // Drain every pending status and let the block settle before config is written.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic cfg_write(input logic idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge i_clk);
        if (idx == CFG_START) cfg_start_addr = v;
        else                  cfg_stack_top  = v;
    endtask

    function automatic t_in cmd(input logic [2:0] c, input logic [15:0] a,
                                input logic [31:0] d);
        t_in it;
        it.command = c; it.address = a; it.data = d;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Directed table: command plus an optional hand-typed status
    // ------------------------------------------------------------------
    typedef struct {
        t_in  it;
        bit   typed;
        t_out exp;
    } t_row;

    t_row dir_rows[$];

    function automatic void row(input t_in it, input bit typed, input t_out e);
        t_row r;
        r.it = it; r.typed = typed; r.exp = e;
        dir_rows.push_back(r);
    endfunction

    function automatic void build_table();
        t_out z;
        z = mk_status('0, MODE_IDLE, '0, '0, '0);
        // nothing runs before start: execute, resume and bad commands are no-ops
        row(cmd(CMD_EXEC,   16'h0000, '0),           1, z);
        row(cmd(CMD_RESUME, 16'h0000, 32'hFFFF_FFFF), 1, z);
        row(cmd(CMD_BAD_LO, 16'h0000, '0),           1, z);
        row(cmd(CMD_BAD_HI, 16'hFFFF, 32'hFFFF_FFFF), 1, z);
        // IMM min-int; PSH; IMM -1; DIV (overflow case); then a bad opcode
        row(cmd(CMD_WRITE, 16'h0000, 32'(OP_IMM)),  1, z);
        row(cmd(CMD_WRITE, 16'h0004, 32'h8000_0000), 1, z);
        row(cmd(CMD_WRITE, 16'h0008, 32'(OP_PSH)),  1, z);
        row(cmd(CMD_WRITE, 16'h000C, 32'(OP_IMM)),  1, z);
        row(cmd(CMD_WRITE, 16'h0010, 32'hFFFF_FFFF), 1, z);
        row(cmd(CMD_WRITE, 16'h0014, 32'(OP_DIV)),  1, z);
        row(cmd(CMD_WRITE, 16'hFFFF, 32'hFFFF_FFFF), 1, z);
        row(cmd(CMD_WRITE, 16'h0018, BAD_OPCODE),   1, z);
        // low address bits are ignored on read
        row(cmd(CMD_READ,  16'hFFFE, '0), 1,
            mk_status(32'hFFFF_FFFF, MODE_IDLE, '0, '0, '0));
        row(cmd(CMD_START, '0, '0), 1, mk_status('0, MODE_RUN, 16'h0000, 16'hFFFC, 0));
        row(cmd(CMD_EXEC,  '0, '0), 1,
            mk_status(32'h8000_0000, MODE_RUN, 16'h0008, 16'hFFFC, 1));
        row(cmd(CMD_EXEC,  '0, '0), 1,
            mk_status(32'h8000_0000, MODE_RUN, 16'h000C, 16'hFFF8, 2));
        row(cmd(CMD_EXEC,  '0, '0), 1,
            mk_status(32'hFFFF_FFFF, MODE_RUN, 16'h0014, 16'hFFF8, 3));
        row(cmd(CMD_EXEC,  '0, '0), 0, z);
        row(cmd(CMD_EXEC,  '0, '0), 1,
            mk_status(32'h8000_0000, MODE_BADOP, 16'h0018, 16'hFFFC, 5));
        row(cmd(CMD_EXEC,  '0, '0), 0, z);   // faulted: ignored
        // same program again, ending in a printf trap and resume
        row(cmd(CMD_WRITE, 16'h0018, 32'(OP_PRTF)), 0, z);
        row(cmd(CMD_START, '0, '0), 1, mk_status('0, MODE_RUN, 16'h0000, 16'hFFFC, 0));
        repeat (5) row(cmd(CMD_EXEC, '0, '0), 0, z);
        row(cmd(CMD_RESUME, '0, 32'h1234_5678), 0, z);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_in         it;
        int          r, steps;
        logic [15:0] sa, st, a;
        logic [31:0] op;

        vm_reset();
        n_sent = 0; n_checked = 0; n_errors = 0;
        n_exec = 0; n_calls = 0; n_halts = 0; n_faults = 0;
        hold_req = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_table();
        foreach (dir_rows[i])
            send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].exp);

        while (n_sent < N_ITEMS) begin
            // new program: config only with the machine drained
            quiesce();
            r  = $urandom_range(0, 9);
            sa = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFC : (r == 2) ? 16'hFFFF :
                 16'($urandom_range(0, 16383) * 4);
            r  = $urandom_range(0, 9);
            st = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'hFFFC :
                 16'($urandom);
            cfg_write(CFG_START, sa);
            cfg_write(CFG_STACK, st);
            cfg_we <= 1'b0;

            // program image at the start address, then a few stack words
            a = sa;
            repeat ($urandom_range(4, 12)) begin
                op = rand_opcode();
                send(cmd(CMD_WRITE, a, op), 1'b0, '0);
                a = a + 16'd4;
                if (op <= 32'(OP_ADJ)) begin
                    send(cmd(CMD_WRITE, a, rand_operand()), 1'b0, '0);
                    a = a + 16'd4;
                end
            end
            for (int k = 0; k < 3; k++)
                send(cmd(CMD_WRITE, st + 16'(k * 4), $urandom), 1'b0, '0);
            issue(cmd(CMD_START, 16'($urandom), $urandom));

            steps = $urandom_range(10, 50);
            while (steps > 0 && n_sent < N_ITEMS) begin
                r = $urandom_range(0, 99);
                if (vm_mode == MODE_CALL && r < 85)
                    it = cmd(CMD_RESUME, 16'($urandom), (r < 40) ? $urandom :
                             32'($urandom_range(0, 8)));
                else if (r < 80) it = cmd(CMD_EXEC, 16'($urandom), $urandom);
                else if (r < 86) it = cmd(CMD_READ,
                                          (r < 83) ? vm_sp : 16'($urandom), $urandom);
                else if (r < 92) it = cmd(CMD_WRITE, 16'($urandom), $urandom);
                else if (r < 94) it = cmd(CMD_START, 16'($urandom), $urandom);
                else if (r < 97) it = cmd(CMD_RESUME, 16'($urandom), $urandom);
                else it = cmd(3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI)),
                              16'($urandom), $urandom);
                issue(it);
                steps--;
                // a stopped machine rarely has more to say
                if (vm_mode inside {MODE_HALT, MODE_BADOP, MODE_DIVZ} && r < 40)
                    steps = 0;
            end
        end

        quiesce();
        $display("Ran %0d commands: %0d instructions, %0d host traps, %0d exits, %0d faults.",
                 n_sent, n_exec, n_calls, n_halts, n_faults);
        $display("Checked %0d status transactions, %0d mismatching fields.",
                 n_checked, n_errors);
        if (n_errors == 0)
            $display("stack_machine_executor: match");
        else
            $display("stack_machine_executor: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall runs, one long hold, field-by-field check
    // ------------------------------------------------------------------
    task automatic check_status(input t_out got);
        t_out e;
        if (status_q.size() == 0) begin
            $error("unexpected status transaction %p", got);
            n_errors++;
            return;
        end
        e = status_q.pop_front();
        n_checked++;
        if (got.value !== e.value) begin
            $error("value: expected %h, got %h", e.value, got.value); n_errors++;
        end
        if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status); n_errors++;
        end
        if (got.host_call !== e.host_call) begin
            $error("host_call: expected %0d, got %0d", e.host_call, got.host_call);
            n_errors++;
        end
        if (got.program_counter !== e.program_counter) begin
            $error("program_counter: expected %h, got %h",
                   e.program_counter, got.program_counter);
            n_errors++;
        end
        if (got.stack_pointer !== e.stack_pointer) begin
            $error("stack_pointer: expected %h, got %h",
                   e.stack_pointer, got.stack_pointer);
            n_errors++;
        end
        if (got.step_count !== e.step_count) begin
            $error("step_count: expected %0d, got %0d", e.step_count, got.step_count);
            n_errors++;
        end
    endtask

    initial begin : receiver
        int  run_left, r;
        run_left = 0;
        forever begin
            @(posedge i_clk);
            if (out_valid && !out_stall) check_status(out_data);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                run_left = 0;
            end
            if (run_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    out_stall <= 1'b1;
                    run_left = $urandom_range(1, 3);
                end else if (r < 28) begin
                    out_stall <= 1'b1;
                    run_left = $urandom_range(20, 60);
                end else begin
                    out_stall <= 1'b0;
                    run_left = (r < 90) ? $urandom_range(1, 20) : $urandom_range(50, 200);
                end
            end
            run_left--;
        end
    end

    // generous ceiling, several times the slowest legal run
    initial begin : watchdog
        #20_000_000;
        $display("stack_machine_executor: mismatch");
        $finish;
    end

endmodule
